FILE: sv/bmp24_pkg.sv
package bmp24_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] PIXEL_OFFSET  = 32'd54;
  localparam logic [31:0] INFO_SIZE     = 32'd40;
  localparam logic [15:0] BITS_24       = 16'd24;

  // Header byte positions
  localparam logic [5:0] IDX_FILE_HDR_END = 6'd13;
  localparam logic [5:0] IDX_INFO_HDR_END = 6'd53;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_SIGNATURE   = 4'd1,
    ERR_OFFSET      = 4'd2,
    ERR_INFO_SIZE   = 4'd3,
    ERR_WIDTH       = 4'd4,
    ERR_HEIGHT      = 4'd5,
    ERR_PLANES      = 4'd6,
    ERR_BITS        = 4'd7,
    ERR_COMPRESSION = 4'd8,
    ERR_IMAGE_SIZE  = 4'd9
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] image_row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;
  } result_t;

endpackage

FILE: sv/bmp24_stream_decoder_core.sv
// Streaming decoder for uncompressed 24-bit BMP files. One file byte per
// transaction on the byte channel, start_of_file marking byte 0 (it restarts
// the parser at any time). The 54-byte header is checked in file order; the
// first failing check gives one error result and later bytes are dropped until
// the next start. A good header gives one header result, then each stored
// blue/green/red triplet gives one pixel result with its column and its row
// counted from the top. Row padding and bytes after the last pixel are
// dropped. A byte can be accepted on every clock while results are taken;
// the result register is the only stage, and the byte channel stalls only
// while it holds a result not yet taken.
module bmp24_stream_decoder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  bmp24_pkg::byte_t  byte_data,
  output logic              result_valid,
  input  logic              result_ready,
  output bmp24_pkg::result_t result_data
);
  import bmp24_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [5:0]  header_index, header_index_next;
  logic [15:0] signature_word, signature_word_next;
  logic [31:0] offset_word, offset_word_next;
  logic [31:0] info_size_word, info_size_word_next;
  logic [31:0] width_word, width_word_next;
  logic [31:0] height_word, height_word_next;
  logic [15:0] planes_word, planes_word_next;
  logic [15:0] bit_count_word, bit_count_word_next;
  logic [31:0] compression_word, compression_word_next;
  logic [31:0] image_size_word, image_size_word_next;
  logic [13:0] padded_line_length, padded_line_length_next;
  logic [13:0] line_bytes, line_bytes_next;
  logic [26:0] image_bytes, image_bytes_next;
  logic [13:0] line_byte_count, line_byte_count_next;
  logic [11:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;
  logic [1:0]  channel_count, channel_count_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;

  logic        accept;
  logic        produce;
  result_t     res;
  phase_t      cur_phase;
  logic [5:0]  idx;
  logic [7:0]  b;
  logic [1:0]  lane4;
  logic        lane2;
  logic [14:0] width_x3;
  logic [14:0] width_pad;
  logic        last;
  logic [13:0] line_byte_inc;
  err_t        code;

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_data.data_byte;

  // Padded line length and image byte count are formed while the remaining
  // header bytes stream in, so the final check is a plain compare.
  assign width_x3  = {2'b00, width_word[12:0]} + {1'b0, width_word[12:0], 1'b0};
  assign width_pad = (width_x3 + 15'd3) & ~15'd3;

  always_comb begin
    phase_next              = phase;
    header_index_next       = header_index;
    signature_word_next     = signature_word;
    offset_word_next        = offset_word;
    info_size_word_next     = info_size_word;
    width_word_next         = width_word;
    height_word_next        = height_word;
    planes_word_next        = planes_word;
    bit_count_word_next     = bit_count_word;
    compression_word_next   = compression_word;
    image_size_word_next    = image_size_word;
    padded_line_length_next = padded_line_length;
    line_bytes_next         = line_bytes;
    image_bytes_next        = image_bytes;
    line_byte_count_next    = line_byte_count;
    column_count_next       = column_count;
    row_count_next          = row_count;
    channel_count_next      = channel_count;
    held_blue_next          = held_blue;
    held_green_next         = held_green;
    produce                 = 1'b0;
    res                     = '0;
    code                    = ERR_NONE;
    last                    = 1'b0;
    lane4                   = 2'd0;
    lane2                   = 1'b0;
    line_byte_inc           = line_byte_count + 14'd1;

    if (byte_data.start_of_file) begin
      signature_word_next   = '0;
      offset_word_next      = '0;
      info_size_word_next   = '0;
      width_word_next       = '0;
      height_word_next      = '0;
      planes_word_next      = '0;
      bit_count_word_next   = '0;
      compression_word_next = '0;
      image_size_word_next  = '0;
      cur_phase             = PH_HEADER;
      idx                   = '0;
    end else begin
      cur_phase = phase;
      idx       = header_index;
    end

    unique case (cur_phase)
      PH_HEADER: begin
        header_index_next = idx + 6'd1;
        if (idx <= 6'd1) begin
          lane2 = idx[0];
          signature_word_next[{lane2, 3'b000} +: 8] = b;
        end else if (idx >= 6'd10 && idx <= 6'd13) begin
          lane4 = 2'(idx - 6'd10);
          offset_word_next[{lane4, 3'b000} +: 8] = b;
        end else if (idx >= 6'd14 && idx <= 6'd17) begin
          lane4 = 2'(idx - 6'd14);
          info_size_word_next[{lane4, 3'b000} +: 8] = b;
        end else if (idx >= 6'd18 && idx <= 6'd21) begin
          lane4 = 2'(idx - 6'd18);
          width_word_next[{lane4, 3'b000} +: 8] = b;
        end else if (idx >= 6'd22 && idx <= 6'd25) begin
          lane4 = 2'(idx - 6'd22);
          height_word_next[{lane4, 3'b000} +: 8] = b;
        end else if (idx >= 6'd26 && idx <= 6'd27) begin
          lane2 = 1'(idx - 6'd26);
          planes_word_next[{lane2, 3'b000} +: 8] = b;
        end else if (idx >= 6'd28 && idx <= 6'd29) begin
          lane2 = 1'(idx - 6'd28);
          bit_count_word_next[{lane2, 3'b000} +: 8] = b;
        end else if (idx >= 6'd30 && idx <= 6'd33) begin
          lane4 = 2'(idx - 6'd30);
          compression_word_next[{lane4, 3'b000} +: 8] = b;
        end else if (idx >= 6'd34 && idx <= 6'd37) begin
          lane4 = 2'(idx - 6'd34);
          image_size_word_next[{lane4, 3'b000} +: 8] = b;
        end

        padded_line_length_next = width_pad[13:0];
        line_bytes_next         = width_x3[13:0];
        image_bytes_next        = 27'(padded_line_length) * 27'(height_word[12:0]);

        if (idx == IDX_FILE_HDR_END) begin
          if (signature_word_next != BMP_SIGNATURE) code = ERR_SIGNATURE;
          else if (offset_word_next != PIXEL_OFFSET) code = ERR_OFFSET;
        end else if (idx == IDX_INFO_HDR_END) begin
          if (info_size_word != INFO_SIZE) code = ERR_INFO_SIZE;
          else if (width_word < 32'd1 || width_word > 32'(MAX_WIDTH)) code = ERR_WIDTH;
          else if (height_word < 32'd1 || height_word > 32'(MAX_HEIGHT)) code = ERR_HEIGHT;
          else if (planes_word != 16'd1) code = ERR_PLANES;
          else if (bit_count_word != BITS_24) code = ERR_BITS;
          else if (compression_word != 32'd0) code = ERR_COMPRESSION;
          else if (image_size_word != {5'b0, image_bytes}) code = ERR_IMAGE_SIZE;

          produce = 1'b1;
          if (code == ERR_NONE) begin
            res.kind             = KIND_HEADER;
            res.image_width      = width_word[12:0];
            res.image_height     = height_word[12:0];
            line_byte_count_next = '0;
            column_count_next    = '0;
            row_count_next       = '0;
            channel_count_next   = '0;
            phase_next           = PH_PIXELS;
          end
        end

        if (code != ERR_NONE) begin
          produce          = 1'b1;
          res              = '0;
          res.kind         = KIND_ERROR;
          res.error_code   = code;
          phase_next       = PH_DONE;
        end else if (idx != IDX_INFO_HDR_END) begin
          phase_next = PH_HEADER;
        end
      end

      PH_PIXELS: begin
        if (line_byte_count < line_bytes) begin
          case (channel_count)
            2'd0: begin
              held_blue_next     = b;
              channel_count_next = 2'd1;
            end
            2'd1: begin
              held_green_next    = b;
              channel_count_next = 2'd2;
            end
            default: begin
              last = ({1'b0, column_count} + 13'd1 == width_word[12:0]) &&
                     ({1'b0, row_count} + 13'd1 == height_word[12:0]);
              produce            = 1'b1;
              res.kind           = KIND_PIXEL;
              res.red            = b;
              res.green          = held_green;
              res.blue           = held_blue;
              res.column         = column_count;
              res.image_row      = height_word[11:0] - 12'd1 - row_count;
              res.last_pixel     = last;
              channel_count_next = 2'd0;
              column_count_next  = column_count + 12'd1;
            end
          endcase
        end
        if (last) begin
          phase_next = PH_DONE;
        end else begin
          line_byte_count_next = line_byte_inc;
          if (line_byte_inc >= padded_line_length) begin
            line_byte_count_next = '0;
            column_count_next    = '0;
            channel_count_next   = '0;
            row_count_next       = row_count + 12'd1;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_index   <= '0;
      result_valid   <= 1'b0;
      signature_word <= '0;
      offset_word    <= '0;
      info_size_word <= '0;
      width_word     <= '0;
      height_word    <= '0;
      planes_word    <= '0;
      bit_count_word <= '0;
      compression_word <= '0;
      image_size_word  <= '0;
      line_byte_count  <= '0;
      column_count     <= '0;
      row_count        <= '0;
      channel_count    <= '0;
    end else begin
      if (accept && produce) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      if (accept) begin
        phase            <= phase_next;
        header_index     <= header_index_next;
        signature_word   <= signature_word_next;
        offset_word      <= offset_word_next;
        info_size_word   <= info_size_word_next;
        width_word       <= width_word_next;
        height_word      <= height_word_next;
        planes_word      <= planes_word_next;
        bit_count_word   <= bit_count_word_next;
        compression_word <= compression_word_next;
        image_size_word  <= image_size_word_next;
        line_byte_count  <= line_byte_count_next;
        column_count     <= column_count_next;
        row_count        <= row_count_next;
        channel_count    <= channel_count_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      padded_line_length <= padded_line_length_next;
      line_bytes         <= line_bytes_next;
      image_bytes        <= image_bytes_next;
      held_blue          <= held_blue_next;
      held_green         <= held_green_next;
      if (produce) result_data <= res;
    end
  end

endmodule

FILE: dv/bmp24_stream_decoder_core_tb.sv
`timescale 1ns / 100ps

module bmp24_stream_decoder_core_tb;
  import bmp24_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_BYTES   = 600;
  localparam int unsigned HDR_BYTES      = 54;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } parse_phase_t;

  // Decodes the accepted byte stream on its own and holds the results the
  // block owes, oldest first.
  class bmp_scoreboard;
    result_t      pending_results[$];
    int unsigned  failures;
    int unsigned  n_pixels;
    int unsigned  n_headers;
    int unsigned  n_errors;
    parse_phase_t phase;
    logic [5:0]   hdr_idx;
    logic [15:0]  sig_w;
    logic [15:0]  planes_w;
    logic [15:0]  bpp_w;
    logic [31:0]  offs_w;
    logic [31:0]  info_w;
    logic [31:0]  wid_w;
    logic [31:0]  hgt_w;
    logic [31:0]  comp_w;
    logic [31:0]  size_w;
    logic [13:0]  line_len;
    logic [13:0]  line_pos;
    logic [11:0]  col;
    logic [11:0]  row;
    logic [1:0]   chan;
    logic [7:0]   held_b;
    logic [7:0]   held_g;

    function new();
      failures  = 0;
      n_pixels  = 0;
      n_headers = 0;
      n_errors  = 0;
      phase     = PH_IDLE;
      restart();
    endfunction

    function void restart();
      hdr_idx  = '0;
      sig_w    = '0;
      planes_w = '0;
      bpp_w    = '0;
      offs_w   = '0;
      info_w   = '0;
      wid_w    = '0;
      hgt_w    = '0;
      comp_w   = '0;
      size_w   = '0;
      line_len = '0;
      line_pos = '0;
      col      = '0;
      row      = '0;
      chan     = '0;
      held_b   = '0;
      held_g   = '0;
    endfunction

    // little-endian merge of a header byte into the word spanning [base, base+len)
    function logic [31:0] merge(logic [31:0] w, int idx, int base, int len, logic [7:0] b);
      if (idx >= base && idx < base + len) begin
        return w | (32'(b) << (8 * (idx - base)));
      end
      return w;
    endfunction

    function err_t check_info();
      logic [63:0] padded;
      if (info_w != INFO_SIZE) return ERR_INFO_SIZE;
      if (wid_w < 1 || wid_w > MAX_WIDTH) return ERR_WIDTH;
      if (hgt_w < 1 || hgt_w > MAX_HEIGHT) return ERR_HEIGHT;
      if (planes_w != 16'd1) return ERR_PLANES;
      if (bpp_w != BITS_24) return ERR_BITS;
      if (comp_w != 32'd0) return ERR_COMPRESSION;
      padded = (64'(wid_w) * 3 + 3) & ~64'd3;
      if (64'(size_w) != padded * 64'(hgt_w)) return ERR_IMAGE_SIZE;
      line_len = padded[13:0];
      return ERR_NONE;
    endfunction

    function void push_error(err_t code);
      result_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      pending_results.push_back(r);
      phase = PH_DONE;
    endfunction

    function void decode_byte(byte_t in);
      result_t    r;
      err_t       code;
      logic [7:0] b;
      int         idx;
      bit         last;
      b = in.data_byte;
      if (in.start_of_file) begin
        restart();
        phase = PH_HEADER;
      end
      case (phase)
        PH_HEADER: begin
          idx      = hdr_idx;
          sig_w    = 16'(merge(32'(sig_w), idx, 0, 2, b));
          offs_w   = merge(offs_w, idx, 10, 4, b);
          info_w   = merge(info_w, idx, 14, 4, b);
          wid_w    = merge(wid_w, idx, 18, 4, b);
          hgt_w    = merge(hgt_w, idx, 22, 4, b);
          planes_w = 16'(merge(32'(planes_w), idx, 26, 2, b));
          bpp_w    = 16'(merge(32'(bpp_w), idx, 28, 2, b));
          comp_w   = merge(comp_w, idx, 30, 4, b);
          size_w   = merge(size_w, idx, 34, 4, b);
          hdr_idx  = hdr_idx + 6'd1;
          if (idx == IDX_FILE_HDR_END) begin
            if (sig_w != BMP_SIGNATURE) push_error(ERR_SIGNATURE);
            else if (offs_w != PIXEL_OFFSET) push_error(ERR_OFFSET);
          end else if (idx == IDX_INFO_HDR_END) begin
            code = check_info();
            if (code != ERR_NONE) begin
              push_error(code);
            end else begin
              r              = '0;
              r.kind         = KIND_HEADER;
              r.image_width  = wid_w[12:0];
              r.image_height = hgt_w[12:0];
              pending_results.push_back(r);
              line_pos = '0;
              col      = '0;
              row      = '0;
              chan     = '0;
              phase    = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          // bytes past width*3 in a line are padding
          if (32'(line_pos) < wid_w * 3) begin
            if (chan == 2'd0) begin
              held_b = b;
              chan   = 2'd1;
            end else if (chan == 2'd1) begin
              held_g = b;
              chan   = 2'd2;
            end else begin
              last = (32'(col) + 1 == wid_w) && (32'(row) + 1 == hgt_w);
              r            = '0;
              r.kind       = KIND_PIXEL;
              r.red        = b;
              r.green      = held_g;
              r.blue       = held_b;
              r.column     = col;
              r.image_row  = 12'(hgt_w - 1 - 32'(row));
              r.last_pixel = last;
              pending_results.push_back(r);
              chan = 2'd0;
              col  = col + 12'd1;
              if (last) begin
                phase = PH_DONE;
                return;
              end
            end
          end
          line_pos = line_pos + 14'd1;
          if (line_pos >= line_len) begin
            line_pos = '0;
            col      = '0;
            chan     = '0;
            row      = row + 12'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      cmp_field("kind", want.kind, got.kind);
      cmp_field("error_code", want.error_code, got.error_code);
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("column", want.column, got.column);
      cmp_field("image_row", want.image_row, got.image_row);
      cmp_field("image_width", want.image_width, got.image_width);
      cmp_field("image_height", want.image_height, got.image_height);
      cmp_field("last_pixel", want.last_pixel, got.last_pixel);
      case (want.kind)
        KIND_PIXEL:  n_pixels++;
        KIND_HEADER: n_headers++;
        default:     n_errors++;
      endcase
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    byte_valid;
  logic    byte_ready;
  byte_t   byte_data;
  logic    result_valid;
  logic    result_ready;
  result_t result_data;

  bmp_scoreboard sb;
  byte_t         byte_stream[$];
  int unsigned   file_bytes;
  int unsigned   n_files;
  int unsigned   stall_cycles;
  int            src_burst;
  int            sink_burst;

  bmp24_stream_decoder_core DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // random idle gap before a transaction, with occasional runs of back-to-back transactions
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 60);
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [31:0] bad_dim(int unsigned limit);
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return $urandom_range(limit + 1, 65535);
      2:       return 32'h8000_0000 | $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  task automatic put_byte(logic [7:0] d, logic sof);
    byte_t t;
    t.data_byte     = d;
    t.start_of_file = sof;
    byte_stream.push_back(t);
  endtask

  // One file: header with at most one broken field, then pixel data for a
  // good header. keep < 0 or beyond the file sends it whole, otherwise it is cut after keep bytes.
  task automatic add_file(err_t err, int w, int h, int keep);
    logic [8*HDR_BYTES-1:0] hdr;
    logic [31:0] padded;
    logic [31:0] wv;
    logic [31:0] hv;
    logic [31:0] img_size;
    int          total;
    int          n;
    int          i;
    for (i = 0; i < HDR_BYTES; i++) hdr[i*8 +: 8] = $urandom_range(0, 255);
    padded   = (w * 3 + 3) & ~3;
    img_size = padded * h;
    wv       = w;
    hv       = h;
    hdr[0 +: 16]   = BMP_SIGNATURE;
    hdr[80 +: 32]  = PIXEL_OFFSET;
    hdr[112 +: 32] = INFO_SIZE;
    hdr[208 +: 16] = 16'd1;
    hdr[224 +: 16] = BITS_24;
    hdr[240 +: 32] = 32'd0;
    case (err)
      ERR_SIGNATURE:   hdr[0 +: 16] ^= 16'(1 << $urandom_range(0, 15));
      ERR_OFFSET:      hdr[80 +: 32] ^= 32'(1) << $urandom_range(0, 31);
      ERR_INFO_SIZE:   hdr[112 +: 32] ^= 32'(1) << $urandom_range(0, 31);
      ERR_WIDTH:       wv = bad_dim(MAX_WIDTH);
      ERR_HEIGHT:      hv = bad_dim(MAX_HEIGHT);
      ERR_PLANES:      hdr[208 +: 16] ^= 16'(1 << $urandom_range(0, 15));
      ERR_BITS:        hdr[224 +: 16] ^= 16'(1 << $urandom_range(0, 15));
      ERR_COMPRESSION: hdr[240 +: 32] ^= 32'(1) << $urandom_range(0, 31);
      ERR_IMAGE_SIZE:  img_size ^= 32'(1) << $urandom_range(0, 31);
      default: ;
    endcase
    hdr[144 +: 32] = wv;
    hdr[176 +: 32] = hv;
    hdr[272 +: 32] = img_size;
    total = HDR_BYTES + ((err == ERR_NONE) ? int'(img_size) : 0);
    n     = (keep < 0 || keep > total) ? total : keep;
    for (i = 0; i < n; i++) begin
      if (i < HDR_BYTES) put_byte(hdr[i*8 +: 8], i == 0);
      else put_byte($urandom_range(0, 255), 1'b0);
    end
    file_bytes += n;
    n_files++;
  endtask

  task automatic add_noise(int n);
    repeat (n) put_byte($urandom_range(0, 255), 1'b0);
  endtask

  task automatic build_directed();
    err_t e;
    // bytes before any start are dropped
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    add_noise(1);
    for (e = ERR_SIGNATURE; e != ERR_NONE; e = e.next()) begin
      add_file(e, 2, 2, -1);
      add_noise(2);
    end
    add_file(ERR_NONE, 1, 1, -1);
    add_noise(2);
    add_file(ERR_NONE, 4, 2, -1);
    // restart in the middle of a header, then in the middle of pixel data
    add_file(ERR_NONE, 2, 2, 30);
    add_file(ERR_NONE, 3, 3, HDR_BYTES + 14);
    // largest size: header result, then the first pixels of the bottom row
    add_file(ERR_NONE, MAX_WIDTH, MAX_HEIGHT, HDR_BYTES + 7);
  endtask

  task automatic build_random();
    int unsigned goal;
    err_t        e;
    int          w;
    int          h;
    int          keep;
    goal = file_bytes + RANDOM_BYTES;
    while (file_bytes < goal) begin
      e = ERR_NONE;
      if ($urandom_range(0, 3) == 0) e = err_t'($urandom_range(ERR_SIGNATURE, ERR_IMAGE_SIZE));
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 4);
      end
      keep = -1;
      if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, HDR_BYTES + ((w * 3 + 3) & ~3) * h);
      add_file(e, w, h, keep);
      if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 4));
    end
  endtask

  task automatic send_byte(byte_t t);
    int gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= t;
    do @(posedge clk); while (byte_ready !== 1'b1);
  endtask

  // result sink with random back-pressure
  initial begin
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap(sink_burst);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (result_valid !== 1'b1);
    end
  end

  // check a result before noting the byte of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result_data);
      if (byte_valid && byte_ready) sb.decode_byte(byte_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    file_bytes   = 0;
    n_files      = 0;
    src_burst    = 0;
    sink_burst   = 0;
    rst          <= 1'b1;
    byte_valid   <= 1'b0;
    byte_data    <= '0;
    result_ready <= 1'b0;
    build_directed();
    build_random();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (byte_stream[i]) send_byte(byte_stream[i]);
    byte_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.failures++;
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
    end
    $display("decoded %0d bytes in %0d files, all header checks and restarts included",
             byte_stream.size(), n_files);
    $display("results: %0d headers, %0d header errors, %0d pixels",
             sb.n_headers, sb.n_errors, sb.n_pixels);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bmp24_pkg.sv
sv/bmp24_stream_decoder_core.sv
dv/bmp24_stream_decoder_core_tb.sv
